// File: rtl/sorted_deadline_timer_queue_defines.svh
// Assertion macros shared by the timer queue RTL.
// Included by every module that carries concurrent assertions; needs nothing else.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define TDQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("timer queue assertion failed");
`define TDQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("timer queue invariant violated");
`else
`define TDQ_ASSERT(lbl, clk, rst_n, prop)
`define TDQ_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/tdq_pkg.sv
// Shared constants, codes and controller/datapath interface types of the timer queue.
// Used by tdq_ctrl, tdq_dp and sorted_deadline_timer_queue; depends on nothing.
`default_nettype none
package tdq_pkg;

	localparam int SLOTS     = 64;
	localparam int TIME_BITS = 32;
	localparam int SLOT_ID_W = 6;
	localparam int CELL_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int LVL       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_ADJUST = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_TICK   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ARMED     = 2'd1,
		ST_NOT_ARMED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_REMOVE,
		OP_POP,
		OP_INSERT
	} dp_op_t;

	typedef struct packed {
		dp_op_t                 op;
		logic                   clr_armed;
		logic [SLOT_ID_W-1:0]   slot_id;
		logic [TIME_BITS-1:0]   expire_time;
		logic [TIME_BITS-1:0]   now_time;
	} dp_cmd_t;

	typedef struct packed {
		logic                   armed;
		logic                   head_exp;
		logic                   next_exp;
		logic [SLOT_ID_W-1:0]   head_id;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue: up to tdq_pkg::SLOTS timers kept in a row of cells in ascending
// expiry order (first-in first-out among equal expiries). Requests are taken one at a time:
// add passes the check and insert states, adjust check, remove, place and insert, delete
// check and remove, a rejected request check alone; the cell row is written once per cycle
// and the insert position needs a registered compare across all cells first. Tick delivers
// one expired timer per beat. in_ready is high only between requests; a finished result waits
// in the output register, so the next request can be accepted before it is taken.
// Uses tdq_pkg, tdq_ctrl and tdq_dp.
`default_nettype none
module sorted_deadline_timer_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    action,
	input  wire logic [tdq_pkg::SLOT_ID_W-1:0] slot_id,
	input  wire logic [31:0]                   expire_time,
	input  wire logic [31:0]                   now_time,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tdq_pkg::SLOT_ID_W-1:0]      expired_id,
	output logic                               expired_valid,
	output logic [1:0]                         status,
	output logic                               last
);

	tdq_pkg::dp_cmd_t  cmd;
	tdq_pkg::dp_stat_t stat;
	tdq_pkg::status_t  status_code;

	tdq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (tdq_pkg::action_t'(action)),
		.slot_id       (slot_id),
		.expire_time   (expire_time),
		.now_time      (now_time),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.expired_id    (expired_id),
		.expired_valid (expired_valid),
		.status        (status_code),
		.last          (last),
		.cmd           (cmd),
		.stat          (stat)
	);

	tdq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign status = status_code;

endmodule
`default_nettype wire

// File: rtl/tdq_dp.sv
// Datapath of the timer queue: the sorted row of cells, the armed bits and the fill count.
// Uses tdq_pkg for sizes and the command/status structs.
`default_nettype none
`include "sorted_deadline_timer_queue_defines.svh"
module tdq_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tdq_pkg::dp_cmd_t cmd,
	output tdq_pkg::dp_stat_t     stat
);

	localparam int SLOTS = tdq_pkg::SLOTS;
	localparam int TB    = tdq_pkg::TIME_BITS;
	localparam int IDW   = tdq_pkg::SLOT_ID_W;
	localparam int CW    = tdq_pkg::CELL_W;
	localparam int NW    = tdq_pkg::CNT_W;
	localparam int LVL   = tdq_pkg::LVL;

	logic [IDW-1:0]   id_q   [SLOTS];
	logic [TB-1:0]    exp_q  [SLOTS];
	logic [IDW-1:0]   up_id  [SLOTS];
	logic [TB-1:0]    up_exp [SLOTS];
	logic [IDW-1:0]   dn_id  [SLOTS];
	logic [TB-1:0]    dn_exp [SLOTS];
	logic [SLOTS-1:0] le_prev;
	logic [NW-1:0]    cnt_q;
	logic [SLOTS-1:0] armed_q;
	logic [SLOTS-1:0] valid;
	logic [SLOTS-1:0] le;
	logic [SLOTS-1:0] le_q;
	logic [SLOTS-1:0] after_q;
	logic [SLOTS-1:0] pre [LVL+1];
	logic [CW-1:0]    cmd_idx;
	logic [CW-1:0]    head_idx;

	assign cmd_idx  = cmd.slot_id[CW-1:0];
	assign head_idx = id_q[0][CW-1:0];

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			valid[i] = (NW'(i) < cnt_q);
			le[i]    = valid[i] && (exp_q[i] <= cmd.expire_time);
		end
	end

	// Prefix OR of the id match, in log levels: a cell at or behind the match
	// takes its successor on a removal.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			pre[0][i] = valid[i] && (id_q[i] == cmd.slot_id);
		end
		for (int k = 0; k < LVL; k++) begin
			for (int i = 0; i < SLOTS; i++) begin
				pre[k+1][i] = pre[k][i];
				if (i >= (1 << k)) begin
					pre[k+1][i] = pre[k][i] | pre[k][i - (1 << k)];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q    <= '0;
			after_q <= '0;
		end else begin
			le_q    <= le;
			after_q <= pre[LVL];
		end
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		if (g == SLOTS - 1) begin : g_tail
			assign up_id[g]  = id_q[g];
			assign up_exp[g] = exp_q[g];
		end else begin : g_body
			assign up_id[g]  = id_q[g+1];
			assign up_exp[g] = exp_q[g+1];
		end
		if (g == 0) begin : g_head
			assign dn_id[g]   = cmd.slot_id;
			assign dn_exp[g]  = cmd.expire_time;
			assign le_prev[g] = 1'b1;
		end else begin : g_rest
			assign dn_id[g]   = id_q[g-1];
			assign dn_exp[g]  = exp_q[g-1];
			assign le_prev[g] = le_q[g-1];
		end

		always_ff @(posedge clk) begin
			unique case (cmd.op)
				tdq_pkg::OP_REMOVE: begin
					if (after_q[g]) begin
						id_q[g]  <= up_id[g];
						exp_q[g] <= up_exp[g];
					end
				end
				tdq_pkg::OP_POP: begin
					id_q[g]  <= up_id[g];
					exp_q[g] <= up_exp[g];
				end
				tdq_pkg::OP_INSERT: begin
					if (!le_q[g]) begin
						if (le_prev[g]) begin
							id_q[g]  <= cmd.slot_id;
							exp_q[g] <= cmd.expire_time;
						end else begin
							id_q[g]  <= dn_id[g];
							exp_q[g] <= dn_exp[g];
						end
					end
				end
				tdq_pkg::OP_IDLE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			armed_q <= '0;
		end else begin
			unique case (cmd.op)
				tdq_pkg::OP_REMOVE: begin
					cnt_q <= cnt_q - NW'(1);
					if (cmd.clr_armed) begin
						armed_q[cmd_idx] <= 1'b0;
					end
				end
				tdq_pkg::OP_POP: begin
					cnt_q             <= cnt_q - NW'(1);
					armed_q[head_idx] <= 1'b0;
				end
				tdq_pkg::OP_INSERT: begin
					cnt_q            <= cnt_q + NW'(1);
					armed_q[cmd_idx] <= 1'b1;
				end
				tdq_pkg::OP_IDLE: begin
				end
			endcase
		end
	end

	assign stat.armed    = armed_q[cmd_idx];
	assign stat.head_id  = id_q[0];
	assign stat.head_exp = valid[0] && (exp_q[0] < cmd.now_time);
	assign stat.next_exp = valid[1] && (exp_q[1] < cmd.now_time);

	`TDQ_ASSERT_NEVER(a_count_bound, clk, arst_n, cnt_q > NW'(SLOTS))
	`TDQ_ASSERT(a_head_sorted, clk, arst_n, valid[1] |-> exp_q[0] <= exp_q[1])
	`TDQ_ASSERT(a_pop_disarms, clk, arst_n, cmd.op == tdq_pkg::OP_POP |=> !armed_q[$past(head_idx)])

endmodule
`default_nettype wire

// File: rtl/tdq_ctrl.sv
// Controller of the timer queue: sequences each request and owns the result register.
// Uses tdq_pkg for codes and the command/status structs; drives tdq_dp.
`default_nettype none
`include "sorted_deadline_timer_queue_defines.svh"
module tdq_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire tdq_pkg::action_t                  action,
	input  wire logic [tdq_pkg::SLOT_ID_W-1:0]     slot_id,
	input  wire logic [31:0]                       expire_time,
	input  wire logic [31:0]                       now_time,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [tdq_pkg::SLOT_ID_W-1:0]          expired_id,
	output logic                                   expired_valid,
	output tdq_pkg::status_t                       status,
	output logic                                   last,
	output tdq_pkg::dp_cmd_t                       cmd,
	input  wire tdq_pkg::dp_stat_t                 stat
);

	localparam int TB  = tdq_pkg::TIME_BITS;
	localparam int IDW = tdq_pkg::SLOT_ID_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_REMOVE,
		S_PLACE,
		S_INSERT,
		S_TICK,
		S_RESULT
	} state_t;

	state_t             state_q;
	tdq_pkg::action_t   act_q;
	logic [IDW-1:0]     id_q;
	logic [TB-1:0]      exp_q;
	logic [TB-1:0]      now_q;
	tdq_pkg::status_t   res_q;
	logic               out_valid_q;
	logic [IDW-1:0]     expired_id_q;
	logic               expired_valid_q;
	tdq_pkg::status_t   status_q;
	logic               last_q;
	logic               out_free;
	logic               out_load;
	logic               id_oob;

	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && (state_q == S_RESULT || state_q == S_TICK);
	assign id_oob   = ({1'b0, id_q} >= (IDW+1)'(tdq_pkg::SLOTS));
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op          = tdq_pkg::OP_IDLE;
		cmd.clr_armed   = (act_q == tdq_pkg::ACT_DELETE);
		cmd.slot_id     = id_q;
		cmd.expire_time = exp_q;
		cmd.now_time    = now_q;
		unique case (state_q)
			S_REMOVE: cmd.op = tdq_pkg::OP_REMOVE;
			S_INSERT: cmd.op = tdq_pkg::OP_INSERT;
			S_TICK: begin
				if (out_free && stat.head_exp) begin
					cmd.op = tdq_pkg::OP_POP;
				end
			end
			S_IDLE, S_CHECK, S_PLACE, S_RESULT: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			act_q           <= tdq_pkg::ACT_ADD;
			id_q            <= '0;
			exp_q           <= '0;
			now_q           <= '0;
			res_q           <= tdq_pkg::ST_OK;
			out_valid_q     <= 1'b0;
			expired_id_q    <= '0;
			expired_valid_q <= 1'b0;
			status_q        <= tdq_pkg::ST_OK;
			last_q          <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						id_q    <= slot_id;
						exp_q   <= TB'(expire_time);
						now_q   <= TB'(now_time);
						res_q   <= tdq_pkg::ST_OK;
						state_q <= (action == tdq_pkg::ACT_TICK) ? S_TICK : S_CHECK;
					end
				end
				S_CHECK: begin
					priority if (id_oob) begin
						res_q   <= tdq_pkg::ST_NOT_ARMED;
						state_q <= S_RESULT;
					end else if (act_q == tdq_pkg::ACT_ADD && stat.armed) begin
						res_q   <= tdq_pkg::ST_ARMED;
						state_q <= S_RESULT;
					end else if (act_q == tdq_pkg::ACT_ADD) begin
						state_q <= S_INSERT;
					end else if (!stat.armed) begin
						res_q   <= tdq_pkg::ST_NOT_ARMED;
						state_q <= S_RESULT;
					end else begin
						state_q <= S_REMOVE;
					end
				end
				S_REMOVE: begin
					state_q <= (act_q == tdq_pkg::ACT_DELETE) ? S_RESULT : S_PLACE;
				end
				S_PLACE: begin
					state_q <= S_INSERT;
				end
				S_INSERT: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						expired_id_q    <= '0;
						expired_valid_q <= 1'b0;
						status_q        <= res_q;
						last_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_TICK: begin
					if (out_free) begin
						status_q    <= tdq_pkg::ST_OK;
						if (stat.head_exp) begin
							// The head is popped this cycle; the next cell decides the end.
							expired_id_q    <= stat.head_id;
							expired_valid_q <= 1'b1;
							last_q          <= !stat.next_exp;
							if (!stat.next_exp) begin
								state_q <= S_IDLE;
							end
						end else begin
							expired_id_q    <= '0;
							expired_valid_q <= 1'b0;
							last_q          <= 1'b1;
							state_q         <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign expired_id    = expired_id_q;
	assign expired_valid = expired_valid_q;
	assign status        = status_q;
	assign last          = last_q;

	`TDQ_ASSERT(a_plain_result_last, clk, arst_n, out_valid_q && !expired_valid_q |-> last_q)
	`TDQ_ASSERT_NEVER(a_no_double_arm, clk, arst_n, cmd.op == tdq_pkg::OP_INSERT && act_q == tdq_pkg::ACT_ADD && stat.armed)
	`TDQ_ASSERT(a_pop_only_in_tick, clk, arst_n, cmd.op == tdq_pkg::OP_POP |-> act_q == tdq_pkg::ACT_TICK)

endmodule
`default_nettype wire

// File: dv/sorted_deadline_timer_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_deadline_timer_queue: a clocked driver and monitor around the
// block, with a sorted timer list that predicts every reply. Depends on tdq_pkg and the block.
module sorted_deadline_timer_queue_tb;

	localparam int NUM_SLOTS = 64;
	localparam int RANDOM_ITEMS = 260;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		tdq_pkg::action_t act;
		logic [5:0]       id;
		logic [31:0]      expiry;
		logic [31:0]      now;
		bit               drain;
	} timer_req_t;

	typedef struct {
		logic [5:0]       id;
		logic             fired;
		tdq_pkg::status_t st;
		logic             last;
	} timer_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = 2'd0;
	logic [5:0]  slot_id = 6'd0;
	logic [31:0] expire_time = 32'd0;
	logic [31:0] now_time = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  expired_id;
	logic        expired_valid;
	logic [1:0]  status;
	logic        last;

	timer_req_t   request_q[$];
	timer_reply_t reply_q[$];
	timer_req_t   cur_req;
	timer_reply_t want;

	// Predicted block state.
	logic        timer_armed[NUM_SLOTS];
	logic [31:0] timer_expiry[NUM_SLOTS];
	logic [5:0]  timer_order[$];

	// Stimulus shadow, used only to pick well-formed requests ahead of time.
	logic        gen_armed[NUM_SLOTS];
	logic [31:0] gen_expiry[NUM_SLOTS];
	logic [31:0] gen_now;

	int beats_due = 0;
	int due_next = 0;
	int beats_seen = 0;
	int fail_count = 0;
	int gap_left = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_phase = 0;
	logic [31:0] stall_pat = 32'hffff_ffff;

	sorted_deadline_timer_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.slot_id(slot_id),
		.expire_time(expire_time),
		.now_time(now_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.expired_id(expired_id),
		.expired_valid(expired_valid),
		.status(status),
		.last(last)
	);

	always #5 clk = ~clk;

	// Timers of equal expiry keep arrival order, so a timer goes behind all its equals.
	function automatic void place_timer(logic [5:0] id);
		int pos;
		pos = 0;
		while (pos < timer_order.size() && timer_expiry[timer_order[pos]] <= timer_expiry[id])
			pos++;
		timer_order.insert(pos, id);
	endfunction

	function automatic int predict_replies(timer_req_t r);
		logic [5:0] fired_ids[$];
		logic [5:0] head;
		fired_ids = {};
		if (r.act == tdq_pkg::ACT_TICK) begin
			while (timer_order.size() != 0 && timer_expiry[timer_order[0]] < r.now) begin
				head = timer_order.pop_front();
				timer_armed[head] = 1'b0;
				fired_ids.push_back(head);
			end
			if (fired_ids.size() == 0) begin
				reply_q.push_back('{6'd0, 1'b0, tdq_pkg::ST_OK, 1'b1});
				return 1;
			end
			for (int i = 0; i < fired_ids.size(); i++)
				reply_q.push_back('{fired_ids[i], 1'b1, tdq_pkg::ST_OK,
					i == fired_ids.size() - 1});
			return fired_ids.size();
		end
		if (r.act == tdq_pkg::ACT_ADD) begin
			if (timer_armed[r.id]) begin
				reply_q.push_back('{6'd0, 1'b0, tdq_pkg::ST_ARMED, 1'b1});
				return 1;
			end
			timer_expiry[r.id] = r.expiry;
			place_timer(r.id);
			timer_armed[r.id] = 1'b1;
		end else begin
			if (!timer_armed[r.id]) begin
				reply_q.push_back('{6'd0, 1'b0, tdq_pkg::ST_NOT_ARMED, 1'b1});
				return 1;
			end
			for (int i = 0; i < timer_order.size(); i++) begin
				if (timer_order[i] == r.id) begin
					timer_order.delete(i);
					break;
				end
			end
			if (r.act == tdq_pkg::ACT_ADJUST) begin
				timer_expiry[r.id] = r.expiry;
				place_timer(r.id);
			end else begin
				timer_armed[r.id] = 1'b0;
			end
		end
		reply_q.push_back('{6'd0, 1'b0, tdq_pkg::ST_OK, 1'b1});
		return 1;
	endfunction

	task automatic enqueue_request(tdq_pkg::action_t a, int id, logic [31:0] t,
			logic [31:0] nw, bit drain);
		request_q.push_back('{a, id[5:0], t, nw, drain});
		case (a)
			tdq_pkg::ACT_ADD: begin
				if (!gen_armed[id]) begin
					gen_armed[id] = 1'b1;
					gen_expiry[id] = t;
				end
			end
			tdq_pkg::ACT_ADJUST: if (gen_armed[id]) gen_expiry[id] = t;
			tdq_pkg::ACT_DELETE: gen_armed[id] = 1'b0;
			default: begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (gen_armed[i] && gen_expiry[i] < nw) gen_armed[i] = 1'b0;
			end
		endcase
	endtask

	function automatic int pick_slot(bit armed_wanted);
		int start;
		int idx;
		start = $urandom_range(0, NUM_SLOTS - 1);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			idx = (start + i) % NUM_SLOTS;
			if (gen_armed[idx] == armed_wanted) return idx;
		end
		return -1;
	endfunction

	function automatic logic [31:0] near_expiry();
		case ($urandom_range(0, 15))
			0: return $urandom;
			1: return gen_now;
			2: return 32'hffff_ffff;
			default: return gen_now + $urandom_range(0, 300);
		endcase
	endfunction

	// Driver: presents requests in bursts with random gaps, holding each one until accepted.
	// The count of expected beats is brought up to date before a draining request is judged.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (in_valid && in_ready)
				due_next = beats_due + predict_replies(cur_req);
			else
				due_next = beats_due;
			beats_due <= due_next;
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (request_q.size() != 0 &&
						!(request_q[0].drain && beats_seen != due_next)) begin
					cur_req = request_q.pop_front();
					in_valid <= 1'b1;
					action <= cur_req.act;
					slot_id <= cur_req.id;
					expire_time <= cur_req.expiry;
					now_time <= cur_req.now;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction; stalls on its own pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			beats_seen <= 0;
			stall_phase = 0;
		end else begin
			if (out_valid && out_ready) begin
				beats_seen <= beats_seen + 1;
				if (reply_q.size() == 0) begin
					$error("result beat with no reply expected (expired_id %0d)", expired_id);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (expired_id !== want.id) begin
						$error("expired_id: expected %0d, got %0d", want.id, expired_id);
						fail_count++;
					end
					if (expired_valid !== want.fired) begin
						$error("expired_valid: expected %0d, got %0d", want.fired,
							expired_valid);
						fail_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fail_count++;
					end
				end
			end
			if (stall_phase == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pat = 32'hffff_ffff;
					1: stall_pat = $urandom | $urandom;
					default: stall_pat = $urandom;
				endcase
			end
			out_ready <= stall_pat[stall_phase];
			stall_phase = (stall_phase + 1) % 32;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("sorted_deadline_timer_queue_tb failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int pick;
		int id;
		int fill_at;
		bit fill_drain;
		logic [31:0] t;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			timer_armed[i] = 1'b0;
			timer_expiry[i] = 32'd0;
			gen_armed[i] = 1'b0;
			gen_expiry[i] = 32'd0;
		end

		// Directed: empty tick, field extremes, error statuses, FIFO among equal expiries,
		// moves both ways, and an expiry equal to the current time.
		enqueue_request(tdq_pkg::ACT_TICK, $urandom_range(0, 63), $urandom, 32'd0, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADD, 0, 32'd0, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADD, 63, 32'hffff_ffff, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADD, 0, 32'd5, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADJUST, 5, 32'd7, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_DELETE, 5, $urandom, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADD, 1, 32'd100, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADD, 2, 32'd100, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADD, 3, 32'd100, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADJUST, 1, 32'd100, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADJUST, 63, 32'd50, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADJUST, 0, 32'd200, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_TICK, $urandom_range(0, 63), $urandom, 32'd50, 1'b0);
		enqueue_request(tdq_pkg::ACT_TICK, $urandom_range(0, 63), $urandom, 32'd101, 1'b0);
		enqueue_request(tdq_pkg::ACT_DELETE, 0, $urandom, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_DELETE, 0, $urandom, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADD, 10, 32'hffff_ffff, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_ADD, 11, 32'd0, $urandom, 1'b0);
		enqueue_request(tdq_pkg::ACT_TICK, $urandom_range(0, 63), $urandom, 32'hffff_ffff,
			1'b0);
		enqueue_request(tdq_pkg::ACT_DELETE, 10, $urandom, $urandom, 1'b0);

		gen_now = $urandom_range(0, 1000);
		fill_at = $urandom_range(60, 160);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == fill_at) begin
				// Arm every free slot with clustered expiries, then fire them all in one tick.
				// The sender first waits for the block to drain completely.
				fill_drain = 1'b1;
				id = pick_slot(1'b0);
				while (id >= 0) begin
					enqueue_request(tdq_pkg::ACT_ADD, id, gen_now + $urandom_range(0, 7),
						$urandom, fill_drain);
					fill_drain = 1'b0;
					n++;
					id = pick_slot(1'b0);
				end
				enqueue_request(tdq_pkg::ACT_TICK, $urandom_range(0, 63), $urandom,
					32'hffff_fffe, fill_drain);
				gen_now = $urandom_range(0, 1000);
				continue;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				enqueue_request(tdq_pkg::action_t'($urandom_range(0, 3)),
					$urandom_range(0, 63), $urandom, $urandom, $urandom_range(0, 39) == 0);
			end else if (pick < 76) begin
				if (pick < 38) begin
					id = pick_slot(1'b0);
					if (id < 0) id = pick_slot(1'b1);
					enqueue_request(tdq_pkg::ACT_ADD, id, near_expiry(), $urandom, 1'b0);
				end else if (pick < 68) begin
					id = pick_slot(1'b1);
					if (id < 0)
						enqueue_request(tdq_pkg::ACT_ADD, pick_slot(1'b0), near_expiry(),
							$urandom, 1'b0);
					else
						enqueue_request(pick < 55 ? tdq_pkg::ACT_ADJUST : tdq_pkg::ACT_DELETE,
							id, near_expiry(), $urandom, 1'b0);
				end else begin
					// Error requests: add to an armed slot, adjust or delete of a free one.
					id = pick_slot(1'b1);
					if (id >= 0 && pick < 72) begin
						enqueue_request(tdq_pkg::ACT_ADD, id, $urandom, $urandom, 1'b0);
					end else begin
						id = pick_slot(1'b0);
						if (id < 0) id = 0;
						enqueue_request(pick < 74 ? tdq_pkg::ACT_ADJUST : tdq_pkg::ACT_DELETE,
							id, $urandom, $urandom, 1'b0);
					end
				end
			end else begin
				gen_now = gen_now + $urandom_range(0, 120);
				t = ($urandom_range(0, 19) == 0) ? $urandom : gen_now;
				enqueue_request(tdq_pkg::ACT_TICK, $urandom_range(0, 63), $urandom, t, 1'b0);
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || in_valid) @(posedge clk);
		while (beats_seen != beats_due) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && reply_q.size() == 0) begin
			$display("sorted_deadline_timer_queue_tb passed");
		end else begin
			if (reply_q.size() != 0)
				$error("%0d predicted replies never arrived", reply_q.size());
			$display("sorted_deadline_timer_queue_tb failed");
		end
		$finish;
	end
endmodule
